@@ hw/rtl/wspa_pkg.sv @@
// wspa_pkg: shared types and constants of the watch slot pool allocator.
// Used by wspa_ctrl, wspa_dp and watch_slot_pool_allocator; depends on nothing.
`default_nettype none

package wspa_pkg;

	localparam int LINK_W = 6;
	localparam int SLOT_W = 5;
	localparam logic [LINK_W-1:0] NULL_LINK = 6'h3F;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_FIND    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_ACTIVE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_REL_CHK,
		S_REL_WALK,
		S_REL_UNLINK,
		S_REL_PUSH,
		S_FIND
	} ctl_state_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_ALLOC,
		DP_REL_HEAD,
		DP_STEP,
		DP_UNLINK,
		DP_PUSH
	} dp_op_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FREE,
		SEL_TARGET
	} slot_sel_t;

	typedef struct packed {
		dp_op_t    op;
		logic      fin;
		status_t   fin_status;
		slot_sel_t fin_slot;
		logic      fin_empty;
	} dp_cmd_t;

	typedef struct packed {
		logic free_valid;
		logic target_valid;
		logic target_is_head;
		logic walk_valid;
		logic walk_hit;
		logic link_hit;
		logic count_done;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/wspa_dp.sv @@
// wspa_dp: link table, list heads, walk pointer and result registers.
// Depends on wspa_pkg; driven by the command struct from wspa_ctrl.
`default_nettype none

module wspa_dp import wspa_pkg::*; #(
	parameter int POOL_SLOTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SLOT_W-1:0] slot_number,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	output logic                   done,
	output logic [1:0]             status,
	output logic [SLOT_W-1:0]      granted_slot,
	output logic                   active_empty
);

	localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W = $clog2(POOL_SLOTS + 1);

	logic [LINK_W-1:0] link_q [POOL_SLOTS];
	logic [LINK_W-1:0] active_head_q, free_head_q;
	logic [LINK_W-1:0] target_q, walk_q;
	logic [CNT_W-1:0]  count_q;
	logic              was_empty_q;
	logic              done_q;
	status_t           status_q;
	logic [SLOT_W-1:0] granted_q;
	logic              empty_out_q;

	logic [LINK_W-1:0] rd_addr, rd_data;
	logic              wr_en;
	logic [LINK_W-1:0] wr_addr, wr_data;

	function automatic logic is_slot(input logic [LINK_W-1:0] link);
		return link < LINK_W'(POOL_SLOTS);
	endfunction

	// single read port on the link table
	always_comb begin
		unique case (cmd.op)
			DP_ALLOC:               rd_addr = free_head_q;
			DP_REL_HEAD, DP_UNLINK: rd_addr = target_q;
			default:                rd_addr = walk_q;
		endcase
	end

	assign rd_data = is_slot(rd_addr) ? link_q[rd_addr[IDX_W-1:0]] : NULL_LINK;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = target_q;
		wr_data = free_head_q;
		unique case (cmd.op)
			DP_ALLOC: begin
				wr_en   = 1'b1;
				wr_addr = free_head_q;
				wr_data = active_head_q;
			end
			DP_REL_HEAD, DP_PUSH: begin
				wr_en = 1'b1;
			end
			DP_UNLINK: begin
				wr_en   = 1'b1;
				wr_addr = walk_q;
				wr_data = rd_data;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				link_q[i] <= (i + 1 < POOL_SLOTS) ? LINK_W'(i + 1) : NULL_LINK;
			end
		end else if (wr_en) begin
			link_q[wr_addr[IDX_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_head_q <= NULL_LINK;
			free_head_q   <= '0;
		end else begin
			unique case (cmd.op)
				DP_ALLOC: begin
					free_head_q   <= rd_data;
					active_head_q <= free_head_q;
				end
				DP_REL_HEAD: begin
					active_head_q <= rd_data;
					free_head_q   <= target_q;
				end
				DP_PUSH: begin
					free_head_q <= target_q;
				end
				default: begin
				end
			endcase
		end
	end

	// walk state for release and find
	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD) begin
			target_q    <= {1'b0, slot_number};
			walk_q      <= active_head_q;
			count_q     <= '0;
			was_empty_q <= !is_slot(active_head_q);
		end else if (cmd.op == DP_STEP) begin
			walk_q  <= rd_data;
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status_q    <= cmd.fin_status;
			empty_out_q <= cmd.fin_empty & was_empty_q;
			case (cmd.fin_slot)
				SEL_FREE:   granted_q <= free_head_q[SLOT_W-1:0];
				SEL_TARGET: granted_q <= target_q[SLOT_W-1:0];
				default:    granted_q <= '0;
			endcase
		end
	end

	always_comb begin
		sts.free_valid     = is_slot(free_head_q);
		sts.target_valid   = is_slot(target_q);
		sts.target_is_head = (active_head_q == target_q);
		sts.walk_valid     = is_slot(walk_q);
		sts.walk_hit       = (walk_q == target_q);
		sts.link_hit       = (rd_data == target_q);
		sts.count_done     = (count_q == CNT_W'(POOL_SLOTS));
	end

	assign done         = done_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign active_empty = empty_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/wspa_ctrl.sv @@
// wspa_ctrl: sequencer for allocate, release and find.
// Depends on wspa_pkg; issues commands to wspa_dp and reads its status.
`default_nettype none

module wspa_ctrl import wspa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] operation,
	input  wire dp_sts_t    sts,
	output logic            busy,
	output dp_cmd_t         cmd
);

	ctl_state_t state_q, state_d;
	op_t        op_in;

	assign op_in = op_t'(operation);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op_in)
						OP_ALLOC:   state_d = S_ALLOC;
						OP_RELEASE: state_d = S_REL_CHK;
						OP_FIND:    state_d = S_FIND;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC: state_d = S_IDLE;
			S_REL_CHK: begin
				if (!sts.target_valid || sts.target_is_head) state_d = S_IDLE;
				else state_d = S_REL_WALK;
			end
			S_REL_WALK: begin
				if (sts.count_done || !sts.walk_valid) state_d = S_IDLE;
				else if (sts.link_hit) state_d = S_REL_UNLINK;
			end
			S_REL_UNLINK: state_d = S_REL_PUSH;
			S_REL_PUSH:   state_d = S_IDLE;
			S_FIND: begin
				if (sts.count_done || !sts.walk_valid || sts.walk_hit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op         = DP_NOP;
		cmd.fin        = 1'b0;
		cmd.fin_status = ST_OK;
		cmd.fin_slot   = SEL_ZERO;
		cmd.fin_empty  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = DP_LOAD;
					// unknown operation answers at once with everything zero
					if (op_in == OP_NONE) cmd.fin = 1'b1;
				end
			end
			S_ALLOC: begin
				cmd.fin = 1'b1;
				if (sts.free_valid) begin
					cmd.op       = DP_ALLOC;
					cmd.fin_slot = SEL_FREE;
				end else begin
					cmd.fin_status = ST_FULL;
				end
			end
			S_REL_CHK: begin
				if (!sts.target_valid) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_NOT_ACTIVE;
				end else if (sts.target_is_head) begin
					cmd.op  = DP_REL_HEAD;
					cmd.fin = 1'b1;
				end
			end
			S_REL_WALK: begin
				if (sts.count_done || !sts.walk_valid) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_NOT_ACTIVE;
				end else if (!sts.link_hit) begin
					cmd.op = DP_STEP;
				end
			end
			S_REL_UNLINK: cmd.op = DP_UNLINK;
			S_REL_PUSH: begin
				cmd.op  = DP_PUSH;
				cmd.fin = 1'b1;
			end
			S_FIND: begin
				if (sts.count_done || !sts.walk_valid) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_NOT_ACTIVE;
					cmd.fin_empty  = 1'b1;
				end else if (sts.walk_hit) begin
					cmd.fin       = 1'b1;
					cmd.fin_slot  = SEL_TARGET;
					cmd.fin_empty = 1'b1;
				end else begin
					cmd.op = DP_STEP;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/watch_slot_pool_allocator.sv @@
// watch_slot_pool_allocator: fixed pool of slots on a free stack and an active list.
// Top level; instantiates wspa_ctrl and wspa_dp, types from wspa_pkg.
//
//   channel   handshake          fields
//   command   start / busy       operation, slot_number
//   result    done (strobe)      status, granted_slot, active_empty
//
// one result per item; done pulses in the cycle after the item finishes, and the
// receiver cannot stall it. an unknown code never raises busy. the walk of a
// release other than of the head, or of a find, moves one link a cycle through
// the single read port of the link table, at most POOL_SLOTS links. reset
// restores the chained free stack at once.
`default_nettype none

module watch_slot_pool_allocator import wspa_pkg::*; #(
	parameter int POOL_SLOTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        operation,
	input  wire logic [SLOT_W-1:0] slot_number,
	output logic                   done,
	output logic [1:0]             status,
	output logic [SLOT_W-1:0]      granted_slot,
	output logic                   active_empty
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	wspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	wspa_dp #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.slot_number  (slot_number),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.granted_slot (granted_slot),
		.active_empty (active_empty)
	);

endmodule

`default_nettype wire
